// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Condition that must never be true at a rising edge of clk.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/dws_pkg.sv =====
// ----------------------------------------------------------------------------
// dws_pkg
// Word types and request and status codes of the deque with search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dws_pkg;

  localparam logic [2:0] REQ_ADD_FRONT = 3'd0;
  localparam logic [2:0] REQ_ADD_BACK  = 3'd1;
  localparam logic [2:0] REQ_DEL_FRONT = 3'd2;
  localparam logic [2:0] REQ_DEL_BACK  = 3'd3;
  localparam logic [2:0] REQ_SEARCH    = 3'd4;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [6:0] length;
    logic [1:0] status;
  } out_word_t;

endpackage

// ===== hdl/dws_ram.sv =====
// ----------------------------------------------------------------------------
// dws_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/deque_with_search.sv =====
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue in a ring RAM with a front-to-back linear search.
// ----------------------------------------------------------------------------
// Usage: present a request word on req and raise start; it is taken at a
// rising edge where start is high and busy is low. Every request returns
// exactly one response word on rsp, marked by a one-cycle done strobe. The
// receiver cannot hold responses off, so done is never stretched.
//
// Adds, removals and unused request codes answer without a stall: the
// response appears the cycle after acceptance and busy stays low, so such
// requests may be issued on every cycle. A search on an empty queue also
// answers in the cycle after acceptance. Any other search streams the ring
// RAM through its single read port, one entry per cycle from the front,
// and stops at the first match or at the back entry, with busy high until
// the response is presented.
//
// Synchronous reset empties the queue (front pointer and count cleared) and
// drops any pending response. The RAM contents are not cleared; the count
// keeps the search from ever reading an entry that was not written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module deque_with_search #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dws_pkg::in_word_t  req,
  output logic               done,
  output dws_pkg::out_word_t rsp
);

  import dws_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int LEN_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int VAL_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t               state;
  logic [PTR_W-1:0]     front;
  logic [CNT_W-1:0]     count;

  // Search sequencer: scan_ptr is the next entry to read, left is the
  // number of reads still to issue, last_q marks that the read in flight
  // is the final one and cmp_valid that read data is ready to compare.
  logic [PTR_W-1:0]     scan_ptr;
  logic [CNT_W-1:0]     left;
  logic                 last_q;
  logic                 cmp_valid;
  logic [DATA_WIDTH-1:0] key;

  logic                 accept;
  logic [VAL_W-1:0]     val_ext;
  logic [DATA_WIDTH-1:0] req_val;
  logic                 is_full;
  logic                 is_empty;
  logic [PTR_W-1:0]     front_dec;
  logic [PTR_W-1:0]     front_inc;
  logic [SUM_W-1:0]     back_sum;
  logic [PTR_W-1:0]     back_idx;
  logic [PTR_W-1:0]     scan_inc;

  logic [PTR_W-1:0]     front_next;
  logic [CNT_W-1:0]     count_next;
  logic [1:0]           status_next;
  logic                 start_scan;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic                 ram_re;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                 match;
  logic                 scan_finish;
  logic [LEN_W-1:0]     len_ext;

  assign busy    = (state == ST_SCAN);
  assign accept  = start && !busy;
  assign val_ext = VAL_W'(req.value);
  assign req_val = val_ext[DATA_WIDTH-1:0];

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  // Ring arithmetic; CAPACITY need not be a power of two.
  assign front_dec = (front == '0) ? PTR_W'(CAPACITY - 1) : front - 1'b1;
  assign front_inc = (front == PTR_W'(CAPACITY - 1)) ? '0 : front + 1'b1;
  assign scan_inc  = (scan_ptr == PTR_W'(CAPACITY - 1)) ? '0 : scan_ptr + 1'b1;

  // The back slot is front + count, which stays below twice the capacity
  // whenever an add is allowed, so one conditional subtract wraps it.
  always_comb begin
    back_sum = SUM_W'(front) + SUM_W'(count);
    if (back_sum >= SUM_W'(CAPACITY)) begin
      back_sum = back_sum - SUM_W'(CAPACITY);
    end
    back_idx = back_sum[PTR_W-1:0];
  end

  // Request decode for adds, removals and the start of a search.
  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = STATUS_DONE;
    ram_we      = 1'b0;
    ram_waddr   = back_idx;
    start_scan  = 1'b0;
    case (req.req_type)
      REQ_ADD_FRONT: begin
        if (is_full) begin
          status_next = STATUS_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + 1'b1;
          ram_we     = accept;
          ram_waddr  = front_dec;
        end
      end
      REQ_ADD_BACK: begin
        if (is_full) begin
          status_next = STATUS_FULL;
        end else begin
          count_next = count + 1'b1;
          ram_we     = accept;
        end
      end
      REQ_DEL_FRONT: begin
        if (is_empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      REQ_DEL_BACK: begin
        if (is_empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      REQ_SEARCH: begin
        start_scan = !is_empty;
      end
      default: begin
      end
    endcase
  end

  // Reads happen only while scanning and writes only while idle, so busy
  // acts as the interlock between a write and any later read of that entry.
  assign ram_re      = (state == ST_SCAN) && (left != '0);
  assign match       = cmp_valid && (ram_rdata == key);
  assign scan_finish = (state == ST_SCAN) && cmp_valid && (match || last_q);

  assign len_ext = LEN_W'(count_next);

  dws_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req_val),
    .re   (ram_re),
    .raddr(scan_ptr),
    .rdata(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= '0;
      count     <= '0;
      done      <= 1'b0;
      left      <= '0;
      last_q    <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      done      <= 1'b0;
      cmp_valid <= ram_re;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            front <= front_next;
            count <= count_next;
            if (start_scan) begin
              state  <= ST_SCAN;
              left   <= count;
              last_q <= 1'b0;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (ram_re) begin
            left   <= left - 1'b1;
            last_q <= (left == CNT_W'(1));
          end
          if (scan_finish) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: search key, read pointer and response word.
  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= req_val;
      scan_ptr <= front;
      rsp.found  <= 1'b0;
      rsp.length <= len_ext[6:0];
      rsp.status <= status_next;
    end else if (ram_re) begin
      scan_ptr <= scan_inc;
    end
    if (scan_finish) begin
      rsp.found <= match;
    end
  end

  `ASSERT_NEVER(a_count_bound, count > CNT_W'(CAPACITY),
                "entry count exceeds capacity")
  `ASSERT_NEVER(a_no_write_in_scan, (state == ST_SCAN) && ram_we,
                "RAM written while a search is reading it")
  `ASSERT_NEVER(a_found_status, done && rsp.found && (rsp.status != STATUS_DONE),
                "found flag raised on a refused request")
  `ASSERT_CLK(a_full_refused,
              accept && is_full &&
              ((req.req_type == REQ_ADD_FRONT) || (req.req_type == REQ_ADD_BACK))
              |=> done && (rsp.status == STATUS_FULL) && $stable(count),
              "add on a full queue not refused")

endmodule

// ===== sim/deque_checker.sv =====
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request and response channels of the deque, predicts each
// response word from its own copy of the ring store and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deque_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  dws_pkg::in_word_t  req,
  input  logic               done,
  input  dws_pkg::out_word_t rsp,
  output int                 errors,
  output int                 pending
);

  import dws_pkg::*;

  localparam int DEPTH = 64;

  logic [31:0] ring [DEPTH];
  logic [5:0]  head_slot;
  logic [6:0]  fill;
  out_word_t   awaited_answers [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Applies one request word to the model state and returns its answer.
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t  ans;
    logic [5:0] slot;
    ans = '0;
    ans.status = STATUS_DONE;
    case (w.req_type)
      REQ_ADD_FRONT, REQ_ADD_BACK: begin
        if (fill == 7'(DEPTH)) begin
          ans.status = STATUS_FULL;
        end else begin
          if (w.req_type == REQ_ADD_FRONT) begin
            head_slot = head_slot - 6'd1;
            slot = head_slot;
          end else begin
            slot = head_slot + fill[5:0];
          end
          ring[slot] = w.value;
          fill = fill + 7'd1;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK: begin
        if (fill == 7'd0) begin
          ans.status = STATUS_EMPTY;
        end else begin
          if (w.req_type == REQ_DEL_FRONT) head_slot = head_slot + 6'd1;
          fill = fill - 7'd1;
        end
      end
      REQ_SEARCH: begin
        for (int i = 0; i < int'(fill); i++) begin
          slot = head_slot + 6'(i);
          if (ring[slot] == w.value) begin
            ans.found = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    ans.length = fill;
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      head_slot = '0;
      fill      = '0;
      awaited_answers.delete();
    end else begin
      // A response always belongs to an earlier request, so it is matched
      // before a request taken at this same edge is queued.
      if (done) begin
        if (awaited_answers.size() == 0) begin
          errors++;
          $display("%0t: response with none expected: found=%0d length=%0d status=%0d",
                   $time, rsp.found, rsp.length, rsp.status);
        end else begin
          want = awaited_answers.pop_front();
          if (rsp.found !== want.found || rsp.length !== want.length ||
              rsp.status !== want.status) begin
            errors++;
            $display("%0t: expected found=%0d length=%0d status=%0d, %s",
                     $time, want.found, want.length, want.status,
                     $sformatf("actual found=%0d length=%0d status=%0d",
                               rsp.found, rsp.length, rsp.status));
          end
        end
      end
      if (start && !busy) awaited_answers.push_back(apply_request(req));
    end
    pending = awaited_answers.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives request words into the deque with search, a directed opening and
// then random phases that sweep the queue between empty and full, while a
// checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dws_pkg::*;

  // The limit lies far above the slowest correct run, every random word with
  // its largest idle gap and a search of a full queue; this leaves ample margin.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 2000;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  req;
  logic      done;
  out_word_t rsp;
  int        errors;
  int        pending;
  int        cycles;

  // Values used by the random phases. Searches mostly pick their key from
  // this pool, so that hits happen at all depths and not only misses.
  logic [31:0] value_pool [16];

  deque_with_search i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  deque_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Presents one word after an idle gap and holds it until the block takes
  // it. The task is entered and left just after a falling edge, which is
  // where all inputs change. Start stays high into the next word when that
  // word has no gap, so back-to-back requests are exercised.
  task automatic issue_word(input in_word_t w, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req   = w;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds off new requests until every outstanding response has arrived.
  task automatic drain;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Builds one random request. add_pct steers adds against removals, which
  // moves the fill level toward full or toward empty over a phase.
  function automatic in_word_t random_word(input int add_pct);
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      w.req_type = 3'($urandom_range(5, 7));
    end else if (pick < 25) begin
      w.req_type = REQ_SEARCH;
    end else if ($urandom_range(0, 99) < add_pct) begin
      w.req_type = $urandom_range(0, 1) ? REQ_ADD_BACK : REQ_ADD_FRONT;
    end else begin
      w.req_type = $urandom_range(0, 1) ? REQ_DEL_BACK : REQ_DEL_FRONT;
    end
    case ($urandom_range(0, 7))
      0:       w.value = $urandom;
      1:       w.value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: w.value = value_pool[4'($urandom_range(0, 15))];
    endcase
    return w;
  endfunction

  initial begin : stimulus
    in_word_t directed [$];
    int       sent;
    int       phase_len;
    int       add_pct;
    bit       quiet;
    int       gap;

    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed opening: removals and a search on the empty queue, the unused
    // request codes, an add at the front that wraps the front pointer below
    // zero, searches that hit the first, middle and last entry, two that miss,
    // removals to empty and once more past it, then add, hit, removal, miss.
    directed = '{
      '{REQ_DEL_FRONT, 32'h0},
      '{REQ_DEL_BACK,  32'hFFFF_FFFF},
      '{REQ_SEARCH,    32'h0},
      '{3'd5,          32'h1234_5678},
      '{3'd6,          32'hFFFF_FFFF},
      '{3'd7,          32'h0},
      '{REQ_ADD_FRONT, 32'h0},
      '{REQ_ADD_BACK,  32'hFFFF_FFFF},
      '{REQ_ADD_FRONT, 32'h8000_0001},
      '{REQ_SEARCH,    32'hFFFF_FFFF},
      '{REQ_SEARCH,    32'h8000_0001},
      '{REQ_SEARCH,    32'h0},
      '{REQ_SEARCH,    32'h1234_5678},
      '{REQ_DEL_BACK,  32'h0},
      '{REQ_SEARCH,    32'hFFFF_FFFF},
      '{REQ_DEL_FRONT, 32'h0},
      '{REQ_DEL_FRONT, 32'h0},
      '{REQ_DEL_FRONT, 32'h0},
      '{REQ_ADD_BACK,  32'h5A5A_A5A5},
      '{REQ_SEARCH,    32'h5A5A_A5A5},
      '{REQ_DEL_BACK,  32'h0},
      '{REQ_SEARCH,    32'h5A5A_A5A5}
    };
    foreach (directed[k]) issue_word(directed[k], 0);

    // Let every directed response come back before random traffic starts.
    drain();

    // Random phases. Each phase picks a direction (mostly adding, balanced,
    // or mostly removing) so the fill level keeps sweeping between empty and
    // full, and either runs with no idle cycles or with random gaps.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      foreach (value_pool[k]) value_pool[k] = $urandom;
      phase_len = $urandom_range(50, 250);
      case ($urandom_range(0, 2))
        0:       add_pct = 85;
        1:       add_pct = 50;
        default: add_pct = 15;
      endcase
      quiet = ($urandom_range(0, 2) == 0);
      repeat (phase_len) begin
        gap = quiet ? 0 : $urandom_range(0, 7);
        issue_word(random_word(add_pct), gap);
        sent++;
      end
      // Now and then the sender waits for the queue of answers to empty.
      if ($urandom_range(0, 3) == 0) drain();
    end

    // Wait for the last responses, then give the block a search's worth of
    // cycles to show any stray strobe.
    drain();
    repeat (80) @(negedge clk);

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
